// File: sv/assert_macros.svh
// Assertion macros used by the RTL file heavy_guardian_sketch.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: sv/hgs_pkg.sv
// ----------------------------------------------------------------------------
// hgs_pkg
// Types and constants for the heavy guardian sketch.
// ----------------------------------------------------------------------------
package hgs_pkg;

  localparam int unsigned BucketsDef        = 1024;
  localparam int unsigned CellsPerBucketDef = 8;
  localparam int unsigned LightPerBucketDef = 16;
  localparam int unsigned DecayDepthDef     = 512;
  localparam logic [31:0] ThresholdReset    = 32'd1000;
  localparam int unsigned FpShift           = 16;
  localparam logic [7:0]  LightMax          = 8'd255;
  localparam logic [31:0] CountMax          = 32'hFFFF_FFFF;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncQuery  = 2'd1;
  localparam logic [1:0] FuncTable  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key_hash;
    logic [30:0] random_word;
    logic [8:0]  table_index;
    logic [31:0] table_value;
  } req_t;

  typedef struct packed {
    logic [31:0] estimate;
    logic        heavy_hit;
  } rsp_t;

endpackage

// File: sv/hgs_ram.sv
// ----------------------------------------------------------------------------
// hgs_ram
// Single-port-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hgs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/heavy_guardian_sketch.sv
// ----------------------------------------------------------------------------
// heavy_guardian_sketch
// Frequency sketch: fingerprint cells per bucket with probabilistic decay.
// ----------------------------------------------------------------------------
// Usage: a request on in_* carries func, key hash, random word and decay table
// fields as one struct. One response per request leaves on out_*: estimate for
// queries, heavy_hit for inserts, zero fields otherwise. heavy_threshold is
// written through cfg_we_i / cfg_wdata_i while no request is in flight; the
// user must keep to this, as the block does not enforce it. An accepted
// request launches the reads of the bucket row and the light counter; StRead
// registers the match and least-count choice; StCmp reads the decay entry of
// the chosen count; StWrite, once the response register is free or being
// taken, updates the memories and loads the response register. A new request
// is taken only after that write back, and requests run one at a time, so a
// write back always lands before the next read of the same bucket.
// After reset a clearing pass zeroes the memories and in_stall_o stays high
// meanwhile. heavy_threshold resets to 1000.
// A stalled response holds in the output register; a following request runs
// up to its write back and holds there until the register is taken.
// ----------------------------------------------------------------------------
module heavy_guardian_sketch #(
  parameter int unsigned BUCKETS          = hgs_pkg::BucketsDef,
  parameter int unsigned CELLS_PER_BUCKET = hgs_pkg::CellsPerBucketDef,
  parameter int unsigned LIGHT_PER_BUCKET = hgs_pkg::LightPerBucketDef,
  parameter int unsigned DECAY_DEPTH      = hgs_pkg::DecayDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hgs_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hgs_pkg::rsp_t out_data_o
);
  import hgs_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned LW   = (BUCKETS * LIGHT_PER_BUCKET > 1)
                                 ? $clog2(BUCKETS * LIGHT_PER_BUCKET) : 1;
  localparam int unsigned DW   = $clog2(DECAY_DEPTH);
  localparam int unsigned CW   = (CELLS_PER_BUCKET > 1) ? $clog2(CELLS_PER_BUCKET) : 1;
  localparam int unsigned RowW = CELLS_PER_BUCKET * 48;
  localparam int unsigned ClrN = (BUCKETS > DECAY_DEPTH) ? BUCKETS : DECAY_DEPTH;
  localparam int unsigned ClrW = $clog2(ClrN + 1);
  localparam int unsigned LightClrStep = LIGHT_PER_BUCKET;

  typedef enum logic [2:0] {
    StClear, StIdle, StRead, StCmp, StWrite, StOut
  } state_e;

  state_e state_q;
  logic [ClrW-1:0] clr_q;
  logic [7:0] lclr_q;
  req_t req_q;
  logic [31:0] thr_q;
  logic [31:0] row_cnt_q [CELLS_PER_BUCKET];
  logic [15:0] row_fp_q [CELLS_PER_BUCKET];
  logic [7:0] light_q;
  logic hit_q;
  logic [CW-1:0] sel_q;
  logic [31:0] sel_cnt_q;
  rsp_t rsp_q;
  rsp_t rsp_d;
  logic out_valid_q;

  logic [BW-1:0] bucket;
  logic [LW-1:0] lslot;
  assign bucket = BW'(req_q.key_hash % BUCKETS);
  assign lslot = LW'(bucket * LIGHT_PER_BUCKET + bucket % LIGHT_PER_BUCKET);

  logic [BW-1:0] in_bucket;
  logic [LW-1:0] in_lslot;
  assign in_bucket = BW'(in_data_i.key_hash % BUCKETS);
  assign in_lslot = LW'(in_bucket * LIGHT_PER_BUCKET + in_bucket % LIGHT_PER_BUCKET);

  // memories
  logic row_we, lt_we, dt_we;
  logic [BW-1:0] row_waddr, row_raddr;
  logic [RowW-1:0] row_wdata, row_rdata;
  logic [LW-1:0] lt_waddr, lt_raddr;
  logic [7:0] lt_wdata, lt_rdata;
  logic [DW-1:0] dt_waddr, dt_raddr;
  logic [31:0] dt_wdata, dt_rdata;

  hgs_ram #(.Width(RowW), .Depth(BUCKETS)) u_row (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(row_raddr), .rdata_o(row_rdata));
  hgs_ram #(.Width(8), .Depth(BUCKETS * LIGHT_PER_BUCKET)) u_light (
    .clk_i, .we_i(lt_we), .waddr_i(lt_waddr), .wdata_i(lt_wdata),
    .raddr_i(lt_raddr), .rdata_o(lt_rdata));
  hgs_ram #(.Width(32), .Depth(DECAY_DEPTH)) u_decay (
    .clk_i, .we_i(dt_we), .waddr_i(dt_waddr), .wdata_i(dt_wdata),
    .raddr_i(dt_raddr), .rdata_o(dt_rdata));

  logic in_acc;
  logic wr_go;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  // write back only once the response register is free or being taken
  assign wr_go = (state_q == StWrite) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o = rsp_q;

  // compare stage: first match, and least count with lowest index
  logic [15:0] fp;
  logic match_any;
  logic [CW-1:0] match_idx, min_idx;
  logic [31:0] match_cnt, min_cnt;
  logic [CELLS_PER_BUCKET-1:0][31:0] rd_cnt;
  logic [CELLS_PER_BUCKET-1:0][15:0] rd_fp;
  assign fp = req_q.key_hash[31:FpShift];
  always_comb begin
    for (int k = 0; k < CELLS_PER_BUCKET; k++) begin
      rd_cnt[k] = row_rdata[k*48 +: 32];
      rd_fp[k] = row_rdata[k*48+32 +: 16];
    end
  end
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    match_cnt = '0;
    min_idx = '0;
    min_cnt = rd_cnt[0];
    for (int k = CELLS_PER_BUCKET - 1; k >= 0; k--) begin
      if (rd_fp[k] == fp) begin
        match_any = 1'b1;
        match_idx = CW'(k);
        match_cnt = rd_cnt[k];
      end
    end
    for (int k = 1; k < CELLS_PER_BUCKET; k++) begin
      if (rd_cnt[k] < min_cnt) begin
        min_cnt = rd_cnt[k];
        min_idx = CW'(k);
      end
    end
  end

  logic [31:0] inc_cnt;
  logic decay;
  assign inc_cnt = (sel_cnt_q == CountMax) ? sel_cnt_q : sel_cnt_q + 32'd1;
  assign decay = {1'b0, req_q.random_word} < dt_rdata;

  logic [RowW-1:0] row_new;
  always_comb begin
    for (int k = 0; k < CELLS_PER_BUCKET; k++) begin
      row_new[k*48 +: 32] = row_cnt_q[k];
      row_new[k*48+32 +: 16] = row_fp_q[k];
    end
    if (hit_q) begin
      row_new[48*sel_q +: 32] = inc_cnt;
    end else if (sel_cnt_q <= 32'd1) begin
      row_new[48*sel_q +: 32] = 32'd1;
      row_new[48*sel_q+32 +: 16] = fp;
    end else begin
      row_new[48*sel_q +: 32] = sel_cnt_q - 32'd1;
    end
  end

  always_comb begin
    rsp_d = '0;
    if (req_q.func == FuncInsert) begin
      rsp_d.heavy_hit = hit_q && (inc_cnt == thr_q);
    end else if (req_q.func == FuncQuery) begin
      if (hit_q) begin
        rsp_d.estimate = (sel_cnt_q > 32'd1) ? sel_cnt_q : 32'd1;
      end else begin
        rsp_d.estimate = (light_q > 8'd1) ? 32'(light_q) : 32'd1;
      end
    end
  end

  always_comb begin
    row_we = 1'b0;
    row_waddr = bucket;
    row_wdata = row_new;
    row_raddr = in_bucket;
    lt_we = 1'b0;
    lt_waddr = lslot;
    lt_wdata = (light_q < LightMax) ? light_q + 8'd1 : light_q;
    lt_raddr = in_lslot;
    dt_we = 1'b0;
    dt_waddr = DW'(req_q.table_index);
    dt_wdata = req_q.table_value;
    dt_raddr = (sel_cnt_q < 32'(DECAY_DEPTH - 1)) ? DW'(sel_cnt_q) : DW'(DECAY_DEPTH - 1);
    unique case (state_q)
      StClear: begin
        row_we = clr_q < ClrW'(BUCKETS);
        row_waddr = BW'(clr_q);
        row_wdata = '0;
        lt_we = clr_q < ClrW'(BUCKETS);
        lt_waddr = LW'(clr_q * LightClrStep + lclr_q);
        lt_wdata = '0;
        dt_we = clr_q < ClrW'(DECAY_DEPTH);
        dt_waddr = DW'(clr_q);
        dt_wdata = '0;
      end
      StWrite: begin
        if (wr_go) begin
          if (req_q.func == FuncInsert) begin
            row_we = hit_q || decay;
            lt_we = !hit_q && decay && (sel_cnt_q > 32'd1);
          end
          dt_we = (req_q.func == FuncTable) &&
                  (32'(req_q.table_index) < 32'(DECAY_DEPTH));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      lclr_q <= '0;
      thr_q <= ThresholdReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (wr_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          // sweep light slots of each bucket, then move to next bucket
          if (lclr_q == 8'(LIGHT_PER_BUCKET - 1) || clr_q >= ClrW'(BUCKETS)) begin
            lclr_q <= '0;
            if (clr_q == ClrW'(ClrN - 1)) begin
              state_q <= StIdle;
            end
            clr_q <= clr_q + 1'b1;
          end else begin
            lclr_q <= lclr_q + 8'd1;
          end
        end
        StIdle: begin
          if (in_acc) begin
            req_q <= in_data_i;
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StCmp;
          hit_q <= match_any;
          sel_q <= match_any ? match_idx : min_idx;
          sel_cnt_q <= match_any ? match_cnt : min_cnt;
          light_q <= lt_rdata;
          for (int k = 0; k < CELLS_PER_BUCKET; k++) begin
            row_cnt_q[k] <= rd_cnt[k];
            row_fp_q[k] <= rd_fp[k];
          end
        end
        StCmp: state_q <= StWrite;
        StWrite: begin
          // hold the finished request while the previous response waits
          if (wr_go) begin
            rsp_q <= rsp_d;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, in_acc && state_q != StIdle)
  `ASSERT_IMPL(a_write_then_out, clk_i, rst_ni, state_q == StWrite |=> out_valid_q)
  `ASSERT_NEVER(a_no_accept_clear, clk_i, rst_ni, in_acc && state_q == StClear)
  `ASSERT_IMPL(a_read_follows, clk_i, rst_ni, in_acc |=> state_q == StRead)
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i |=> out_valid_q && $stable(rsp_q))

endmodule
